// ----- rtl/rft_pkg.sv -----
`default_nettype none

package rft_pkg;

    // field widths
    localparam int COORD_W   = 32;
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = COEF_W - 2;
    localparam int BASIS_W   = 3 * COEF_W;
    localparam int CFG_DW    = (BASIS_W > COORD_W) ? BASIS_W : COORD_W;
    localparam int CFG_IDX_W = 3;

    // translation term path: coef * origin, sum of three, rounded
    localparam int P1_W = COEF_W + COORD_W;
    localparam int S1_W = P1_W + 2;
    localparam int T_W  = S1_W - COEF_FRAC;

    // projection path: coef * operand, sum of three, rounded
    localparam int X_W  = T_W + 1;
    localparam int P2_W = COEF_W + X_W;
    localparam int S2_W = P2_W + 2;
    localparam int R_W  = S2_W - COEF_FRAC;

    // register stages from input to output register
    localparam int PIPE_DEPTH = 7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_X  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_Y  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_Z  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = CFG_IDX_W'(5);

    // input codes
    localparam logic OP_TO_GLOBAL = 1'b1;
    localparam logic DIR_VECTOR   = 1'b1;

    localparam logic [S1_W-1:0] HALF1 = S1_W'(1) << (COEF_FRAC - 1);
    localparam logic [S2_W-1:0] HALF2 = S2_W'(1) << (COEF_FRAC - 1);

    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [COORD_W:0]   t_diff;
    typedef logic signed [T_W-1:0]     t_toff;
    typedef logic signed [X_W-1:0]     t_opnd;
    typedef logic signed [P1_W-1:0]    t_prod1;
    typedef logic signed [S1_W-1:0]    t_acc1;
    typedef logic signed [P2_W-1:0]    t_prod2;
    typedef logic signed [S2_W-1:0]    t_acc2;
    typedef logic signed [R_W-1:0]     t_res;

    typedef struct packed {
        t_coef  [2:0][2:0] coef;    // [row][component]
        t_coord [2:0]      origin;
    } t_cfg;

    typedef struct packed {
        logic          op;
        logic          is_dir;
        t_coord [2:0]  v;
    } t_req;

    typedef struct packed {
        logic          op;
        t_coord [2:0]  v;
        t_diff  [2:0]  d;
        t_toff  [2:0]  t;
    } t_mid;

    typedef struct packed {
        t_coord [2:0]  c;
        logic          ovf;
    } t_rsp;

endpackage

`default_nettype wire

// ----- rtl/rft_in_if.sv -----
`default_nettype none

interface rft_in_if;
    logic                   valid;
    logic                   ready;
    logic                   op;
    logic                   is_direction;
    rft_pkg::t_coord        in_x;
    rft_pkg::t_coord        in_y;
    rft_pkg::t_coord        in_z;

    modport source (output valid, output op, output is_direction,
                    output in_x, output in_y, output in_z, input ready);
    modport sink   (input valid, input op, input is_direction,
                    input in_x, input in_y, input in_z, output ready);
endinterface

`default_nettype wire

// ----- rtl/rft_out_if.sv -----
`default_nettype none

interface rft_out_if;
    logic                   valid;
    logic                   ready;
    rft_pkg::t_coord        out_x;
    rft_pkg::t_coord        out_y;
    rft_pkg::t_coord        out_z;
    logic                   overflow;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output overflow, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input overflow, output ready);
endinterface

`default_nettype wire

// ----- rtl/rigid_frame_transform_top.sv -----
`default_nettype none

// Rigid frame transform: converts a signed Q16.16 point or direction between
// the global frame and a local frame set by an origin and three Q2.14 basis
// rows. Global to local gives basis_k . (in - origin); local to global gives
// transpose(basis) * (in + basis * origin), the origin dropped for directions.
// Each dot product is exact and rounded once, half up; results saturate and
// raise overflow. The pipeline is seven register stages deep, the last being
// the output register; one item is taken per clock while the output is not
// stalled. Every stage holds its own item and moves on when the stage after
// it is free, so input ready stays high while the output waits as long as a
// stage further back is empty. The two rows of nine multipliers (16 by 32
// bits, then 16 by 37 bits) set the stage timing. The user must write the
// configuration registers only while no item is in flight; the block itself
// does not enforce it.
module rigid_frame_transform_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rft_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [rft_pkg::CFG_DW-1:0]      i_cfg_data,
    rft_in_if.sink                               i_in,
    rft_out_if.source                            o_out
);

    rft_pkg::t_cfg  cfg;
    rft_pkg::t_req  req;
    rft_pkg::t_mid  mid;
    rft_pkg::t_rsp  rsp;
    logic           mid_vld;
    logic           mid_rdy;

    assign req.op     = i_in.op;
    assign req.is_dir = i_in.is_direction;
    assign req.v[0]   = i_in.in_x;
    assign req.v[1]   = i_in.in_y;
    assign req.v[2]   = i_in.in_z;

    rft_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    rft_offset u_offset (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_vld   (i_in.valid),
        .o_rdy   (i_in.ready),
        .i_req   (req),
        .o_vld   (mid_vld),
        .i_rdy   (mid_rdy),
        .o_mid   (mid)
    );

    rft_project u_project (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_vld   (mid_vld),
        .o_rdy   (mid_rdy),
        .i_mid   (mid),
        .o_vld   (o_out.valid),
        .i_rdy   (o_out.ready),
        .o_rsp   (rsp)
    );

    assign o_out.out_x    = rsp.c[0];
    assign o_out.out_y    = rsp.c[1];
    assign o_out.out_z    = rsp.c[2];
    assign o_out.overflow = rsp.ovf;

endmodule

`default_nettype wire

// ----- rtl/rft_cfg_regs.sv -----
`default_nettype none

module rft_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_we,
    input  wire logic [rft_pkg::CFG_IDX_W-1:0]   i_idx,
    input  wire logic [rft_pkg::CFG_DW-1:0]      i_data,
    output rft_pkg::t_cfg                        o_cfg
);

    logic [rft_pkg::BASIS_W-1:0] r_basis  [3];
    logic [rft_pkg::COORD_W-1:0] r_origin [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                // identity basis
                r_basis[k]  <= rft_pkg::BASIS_W'(1) << (k * rft_pkg::COEF_W
                                                        + rft_pkg::COEF_FRAC);
                r_origin[k] <= '0;
            end
        end else if (i_we) begin
            unique case (i_idx)
                rft_pkg::REG_BASIS_X:  r_basis[0]  <= i_data[rft_pkg::BASIS_W-1:0];
                rft_pkg::REG_BASIS_Y:  r_basis[1]  <= i_data[rft_pkg::BASIS_W-1:0];
                rft_pkg::REG_BASIS_Z:  r_basis[2]  <= i_data[rft_pkg::BASIS_W-1:0];
                rft_pkg::REG_ORIGIN_X: r_origin[0] <= i_data[rft_pkg::COORD_W-1:0];
                rft_pkg::REG_ORIGIN_Y: r_origin[1] <= i_data[rft_pkg::COORD_W-1:0];
                rft_pkg::REG_ORIGIN_Z: r_origin[2] <= i_data[rft_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                o_cfg.coef[k][i] = rft_pkg::t_coef'(
                    r_basis[k][i*rft_pkg::COEF_W +: rft_pkg::COEF_W]);
            end
            o_cfg.origin[k] = rft_pkg::t_coord'(r_origin[k]);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rft_offset.sv -----
`default_nettype none

// stages 1-3: select origin, form difference and translation term
module rft_offset (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rft_pkg::t_cfg i_cfg,
    input  wire logic          i_vld,
    output logic               o_rdy,
    input  wire rft_pkg::t_req i_req,
    output logic               o_vld,
    input  wire logic          i_rdy,
    output rft_pkg::t_mid      o_mid
);

    logic en1, en2, en3;
    logic r1_vld, r2_vld, r3_vld;

    logic                   r1_op;
    rft_pkg::t_coord        r1_v    [3];
    rft_pkg::t_coord        r1_p    [3];

    logic                   r2_op;
    rft_pkg::t_coord        r2_v    [3];
    rft_pkg::t_diff         r2_d    [3];
    rft_pkg::t_prod1        r2_prod [3][3];

    logic                   r3_op;
    rft_pkg::t_coord        r3_v    [3];
    rft_pkg::t_diff         r3_d    [3];
    rft_pkg::t_toff         r3_t    [3];

    rft_pkg::t_acc1         n3_sum  [3];

    assign en3   = !r3_vld || i_rdy;
    assign en2   = !r2_vld || en3;
    assign en1   = !r1_vld || en2;
    assign o_rdy = en1;
    assign o_vld = r3_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            if (en1) begin
                r1_vld <= i_vld;
            end
            if (en2) begin
                r2_vld <= r1_vld;
            end
            if (en3) begin
                r3_vld <= r2_vld;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n3_sum[k] = rft_pkg::t_acc1'(r2_prod[k][0]) + rft_pkg::t_acc1'(r2_prod[k][1])
                      + rft_pkg::t_acc1'(r2_prod[k][2])
                      + rft_pkg::t_acc1'(rft_pkg::HALF1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_vld) begin
            r1_op <= i_req.op;
            for (int i = 0; i < 3; i++) begin
                r1_v[i] <= i_req.v[i];
                r1_p[i] <= (i_req.is_dir == rft_pkg::DIR_VECTOR) ? '0 : i_cfg.origin[i];
            end
        end
        if (en2 && r1_vld) begin
            r2_op <= r1_op;
            for (int i = 0; i < 3; i++) begin
                r2_v[i] <= r1_v[i];
                r2_d[i] <= rft_pkg::t_diff'(r1_v[i]) - rft_pkg::t_diff'(r1_p[i]);
                for (int k = 0; k < 3; k++) begin
                    r2_prod[k][i] <= rft_pkg::t_prod1'(i_cfg.coef[k][i])
                                   * rft_pkg::t_prod1'(r1_p[i]);
                end
            end
        end
        if (en3 && r2_vld) begin
            r3_op <= r2_op;
            for (int i = 0; i < 3; i++) begin
                r3_v[i] <= r2_v[i];
                r3_d[i] <= r2_d[i];
                // round half up: add half, keep the upper bits
                r3_t[i] <= rft_pkg::t_toff'(n3_sum[i][rft_pkg::S1_W-1:rft_pkg::COEF_FRAC]);
            end
        end
    end

    always_comb begin
        o_mid.op = r3_op;
        for (int i = 0; i < 3; i++) begin
            o_mid.v[i] = r3_v[i];
            o_mid.d[i] = r3_d[i];
            o_mid.t[i] = r3_t[i];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rft_project.sv -----
`default_nettype none

// stages 4-7: operand, products, rounded sums, saturation
module rft_project (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rft_pkg::t_cfg i_cfg,
    input  wire logic          i_vld,
    output logic               o_rdy,
    input  wire rft_pkg::t_mid i_mid,
    output logic               o_vld,
    input  wire logic          i_rdy,
    output rft_pkg::t_rsp      o_rsp
);

    logic en4, en5, en6, en7;
    logic r4_vld, r5_vld, r6_vld, r7_vld;

    logic                   r4_op;
    rft_pkg::t_opnd         r4_x    [3];
    rft_pkg::t_prod2        r5_prod [3][3];
    rft_pkg::t_res          r6_acc  [3];
    rft_pkg::t_coord        r7_c    [3];
    logic                   r7_ovf;

    rft_pkg::t_acc2         n6_sum  [3];
    rft_pkg::t_coef         n5_coef [3][3];
    rft_pkg::t_coord        n7_c    [3];
    logic [2:0]             n7_sat;

    assign en7   = !r7_vld || i_rdy;
    assign en6   = !r6_vld || en7;
    assign en5   = !r5_vld || en6;
    assign en4   = !r4_vld || en5;
    assign o_rdy = en4;
    assign o_vld = r7_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else begin
            if (en4) begin
                r4_vld <= i_vld;
            end
            if (en5) begin
                r5_vld <= r4_vld;
            end
            if (en6) begin
                r6_vld <= r5_vld;
            end
            if (en7) begin
                r7_vld <= r6_vld;
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            // local to global uses the transposed basis
            for (int j = 0; j < 3; j++) begin
                n5_coef[r][j] = (r4_op == rft_pkg::OP_TO_GLOBAL) ? i_cfg.coef[j][r]
                                                                  : i_cfg.coef[r][j];
            end
            n6_sum[r] = rft_pkg::t_acc2'(r5_prod[r][0]) + rft_pkg::t_acc2'(r5_prod[r][1])
                      + rft_pkg::t_acc2'(r5_prod[r][2])
                      + rft_pkg::t_acc2'(rft_pkg::HALF2);
            // in range when the bits above the sign all match it
            if ((&r6_acc[r][rft_pkg::R_W-1:rft_pkg::COORD_W-1])
                || !(|r6_acc[r][rft_pkg::R_W-1:rft_pkg::COORD_W-1])) begin
                n7_sat[r] = 1'b0;
                n7_c[r]   = rft_pkg::t_coord'(r6_acc[r][rft_pkg::COORD_W-1:0]);
            end else begin
                n7_sat[r] = 1'b1;
                n7_c[r]   = r6_acc[r][rft_pkg::R_W-1] ? rft_pkg::t_coord'(rft_pkg::COORD_MIN)
                                                      : rft_pkg::t_coord'(rft_pkg::COORD_MAX);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && i_vld) begin
            r4_op <= i_mid.op;
            for (int j = 0; j < 3; j++) begin
                r4_x[j] <= (i_mid.op == rft_pkg::OP_TO_GLOBAL)
                         ? rft_pkg::t_opnd'(i_mid.v[j]) + rft_pkg::t_opnd'(i_mid.t[j])
                         : rft_pkg::t_opnd'(i_mid.d[j]);
            end
        end
        if (en5 && r4_vld) begin
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 3; j++) begin
                    r5_prod[r][j] <= rft_pkg::t_prod2'(n5_coef[r][j])
                                   * rft_pkg::t_prod2'(r4_x[j]);
                end
            end
        end
        if (en6 && r5_vld) begin
            for (int r = 0; r < 3; r++) begin
                r6_acc[r] <= rft_pkg::t_res'(n6_sum[r][rft_pkg::S2_W-1:rft_pkg::COEF_FRAC]);
            end
        end
        if (en7 && r6_vld) begin
            for (int r = 0; r < 3; r++) begin
                r7_c[r] <= n7_c[r];
            end
            r7_ovf <= |n7_sat;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            o_rsp.c[r] = r7_c[r];
        end
        o_rsp.ovf = r7_ovf;
    end

endmodule

`default_nettype wire

// ----- rtl/rft_checker.sv -----
`default_nettype none

module rft_checker (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic [rft_pkg::COORD_W-1:0] i_out_x,
    input  wire logic [rft_pkg::COORD_W-1:0] i_out_y,
    input  wire logic [rft_pkg::COORD_W-1:0] i_out_z,
    input  wire logic                  i_overflow
);

    localparam int CNT_W = $clog2(rft_pkg::PIPE_DEPTH + 2);

    logic [CNT_W-1:0] r_cnt;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // items taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_acc && !out_acc) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (out_acc && !in_acc) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(rft_pkg::PIPE_DEPTH))
        else $error("more items in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != '0)
        else $error("result shown with no item in flight");

    a_ovf_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_overflow) |->
            (i_out_x == rft_pkg::COORD_MAX || i_out_x == rft_pkg::COORD_MIN ||
             i_out_y == rft_pkg::COORD_MAX || i_out_y == rft_pkg::COORD_MIN ||
             i_out_z == rft_pkg::COORD_MAX || i_out_z == rft_pkg::COORD_MIN))
        else $error("overflow flagged without a clamped component");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_x) && $stable(i_out_y)
             && $stable(i_out_z) && $stable(i_overflow)))
        else $error("stalled result changed");

endmodule

bind rigid_frame_transform_top rft_checker u_rft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_x     (o_out.out_x),
    .i_out_y     (o_out.out_y),
    .i_out_z     (o_out.out_z),
    .i_overflow  (o_out.overflow)
);

`default_nettype wire

// ----- tb/sv/tb_rigid_frame_transform_top.sv -----
`timescale 1ns / 1ps

module tb_rigid_frame_transform_top;

    localparam logic OP_TO_LOCAL = ~rft_pkg::OP_TO_GLOBAL;
    localparam logic DIR_POINT   = ~rft_pkg::DIR_VECTOR;

    // indexes past the register list, writes there must be dropped
    localparam logic [rft_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = rft_pkg::CFG_IDX_W'(6);
    localparam logic [rft_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = rft_pkg::CFG_IDX_W'(7);

    localparam rft_pkg::t_coef ONE_Q14   = rft_pkg::t_coef'(16'h4000);
    localparam rft_pkg::t_coef NEG_TWO   = rft_pkg::t_coef'(16'h8000);
    localparam rft_pkg::t_coef MAX_COEF  = rft_pkg::t_coef'(16'h7fff);
    localparam rft_pkg::t_coef LSB_COEF  = rft_pkg::t_coef'(16'h0001);
    localparam rft_pkg::t_coef ZERO_COEF = rft_pkg::t_coef'(16'h0000);

    localparam rft_pkg::t_coord C_MAX = rft_pkg::t_coord'(rft_pkg::COORD_MAX);
    localparam rft_pkg::t_coord C_MIN = rft_pkg::t_coord'(rft_pkg::COORD_MIN);

    localparam int HOLD_LEN = 150;

    typedef struct packed {
        logic                  op;
        logic                  is_dir;
        rft_pkg::t_coord [2:0] v;
    } t_coord_req;

    typedef struct packed {
        rft_pkg::t_coord [2:0] c;
        logic                  ovf;
    } t_coord_res;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [rft_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [rft_pkg::CFG_DW-1:0]    i_cfg_data;

    rft_in_if  in_if ();
    rft_out_if out_if ();

    rigid_frame_transform_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the frame registers
    rft_pkg::t_coef  frame_coef [3][3];
    rft_pkg::t_coord frame_origin [3];

    t_coord_res expected_q [$];

    int src_idle_pct = 35;
    int snk_idle_pct = 35;
    logic stall_burst = 1'b0;
    int hold_left = 0;

    int err_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int sat_results = 0;
    int frames_loaded = 0;

    function automatic logic signed [127:0] round_q14(input logic signed [127:0] a);
        return (a + (128'sd1 <<< (rft_pkg::COEF_FRAC - 1))) >>> rft_pkg::COEF_FRAC;
    endfunction

    function automatic rft_pkg::t_coord clamp_coord(input logic signed [127:0] a,
                                                    output logic sat);
        logic signed [127:0] hi_lim, lo_lim;
        hi_lim = C_MAX;
        lo_lim = C_MIN;
        sat = 1'b0;
        if (a > hi_lim) begin
            sat = 1'b1;
            return C_MAX;
        end else if (a < lo_lim) begin
            sat = 1'b1;
            return C_MIN;
        end
        return rft_pkg::t_coord'(a[rft_pkg::COORD_W-1:0]);
    endfunction

    function automatic t_coord_res transform_coord(input t_coord_req r);
        logic signed [127:0] acc, lhs, rhs;
        longint v [3];
        longint p [3];
        longint w [3];
        logic sat;
        t_coord_res res;
        res.ovf = 1'b0;
        for (int i = 0; i < 3; i++) begin
            v[i] = r.v[i];
            p[i] = (r.is_dir == rft_pkg::DIR_VECTOR) ? 64'sd0 : longint'(frame_origin[i]);
        end
        if (r.op != rft_pkg::OP_TO_GLOBAL) begin
            for (int k = 0; k < 3; k++) begin
                acc = '0;
                for (int i = 0; i < 3; i++) begin
                    lhs = frame_coef[k][i];
                    rhs = v[i] - p[i];
                    acc = acc + lhs * rhs;
                end
                res.c[k] = clamp_coord(round_q14(acc), sat);
                res.ovf |= sat;
            end
        end else begin
            // translation term is rounded but kept at full width
            for (int k = 0; k < 3; k++) begin
                acc = '0;
                for (int i = 0; i < 3; i++) begin
                    lhs = frame_coef[k][i];
                    rhs = p[i];
                    acc = acc + lhs * rhs;
                end
                w[k] = v[k] + longint'(round_q14(acc));
            end
            for (int i = 0; i < 3; i++) begin
                acc = '0;
                for (int k = 0; k < 3; k++) begin
                    lhs = frame_coef[k][i];
                    rhs = w[k];
                    acc = acc + lhs * rhs;
                end
                res.c[i] = clamp_coord(round_q14(acc), sat);
                res.ovf |= sat;
            end
        end
        return res;
    endfunction

    function automatic void reset_frame_model();
        for (int k = 0; k < 3; k++) begin
            frame_origin[k] = '0;
            for (int i = 0; i < 3; i++)
                frame_coef[k][i] = (k == i) ? ONE_Q14 : ZERO_COEF;
        end
    endfunction

    function automatic void apply_reg(input logic [rft_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [rft_pkg::CFG_DW-1:0] data);
        case (idx)
            rft_pkg::REG_BASIS_X:
                for (int c = 0; c < 3; c++)
                    frame_coef[0][c] = data[c*rft_pkg::COEF_W +: rft_pkg::COEF_W];
            rft_pkg::REG_BASIS_Y:
                for (int c = 0; c < 3; c++)
                    frame_coef[1][c] = data[c*rft_pkg::COEF_W +: rft_pkg::COEF_W];
            rft_pkg::REG_BASIS_Z:
                for (int c = 0; c < 3; c++)
                    frame_coef[2][c] = data[c*rft_pkg::COEF_W +: rft_pkg::COEF_W];
            rft_pkg::REG_ORIGIN_X: frame_origin[0] = data[rft_pkg::COORD_W-1:0];
            rft_pkg::REG_ORIGIN_Y: frame_origin[1] = data[rft_pkg::COORD_W-1:0];
            rft_pkg::REG_ORIGIN_Z: frame_origin[2] = data[rft_pkg::COORD_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [rft_pkg::BASIS_W-1:0] basis_row(input rft_pkg::t_coef c0,
                                                              input rft_pkg::t_coef c1,
                                                              input rft_pkg::t_coef c2);
        return {c2, c1, c0};
    endfunction

    function automatic t_coord_req mk_req(input logic op, input logic is_dir,
                                          input rft_pkg::t_coord x, input rft_pkg::t_coord y,
                                          input rft_pkg::t_coord z);
        t_coord_req r;
        r.op = op;
        r.is_dir = is_dir;
        r.v[0] = x;
        r.v[1] = y;
        r.v[2] = z;
        return r;
    endfunction

    function automatic rft_pkg::t_coord rand_coord();
        int s;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return rft_pkg::t_coord'($urandom);
            5, 6, 7: begin
                s = $urandom_range(2097151);
                return rft_pkg::t_coord'(s - 1048576);
            end
            8: return $urandom_range(1) ? C_MAX : C_MIN;
            default: begin
                s = $urandom_range(4);
                return rft_pkg::t_coord'(s - 2);
            end
        endcase
    endfunction

    function automatic rft_pkg::t_coef rand_coef();
        int s;
        case ($urandom_range(7))
            0, 1: return rft_pkg::t_coef'($urandom);
            2, 3: begin
                // near a unit axis, either sign
                s = $urandom_range(512);
                return $urandom_range(1) ? rft_pkg::t_coef'(16384 - s)
                                         : rft_pkg::t_coef'(s - 16384);
            end
            4: return $urandom_range(1) ? NEG_TWO : MAX_COEF;
            5: return ZERO_COEF;
            default: begin
                s = $urandom_range(16384);
                return rft_pkg::t_coef'(s - 8192);
            end
        endcase
    endfunction

    function automatic t_coord_req rand_req();
        t_coord_req r;
        r.op = 1'($urandom_range(1));
        r.is_dir = 1'($urandom_range(1));
        for (int i = 0; i < 3; i++)
            r.v[i] = rand_coord();
        return r;
    endfunction

    task automatic send_item(input t_coord_req r);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.op           <= r.op;
        in_if.is_direction <= r.is_dir;
        in_if.in_x         <= r.v[0];
        in_if.in_y         <= r.v[1];
        in_if.in_z         <= r.v[2];
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        expected_q.push_back(transform_coord(r));
        items_sent++;
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (rft_pkg::PIPE_DEPTH + 3) @(posedge i_clk);
    endtask

    // leaves the write enable high, the caller lowers it after the last write
    task automatic write_reg(input logic [rft_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rft_pkg::CFG_DW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        apply_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic load_frame(input logic [rft_pkg::BASIS_W-1:0] bx,
                              input logic [rft_pkg::BASIS_W-1:0] by,
                              input logic [rft_pkg::BASIS_W-1:0] bz,
                              input rft_pkg::t_coord ox, input rft_pkg::t_coord oy,
                              input rft_pkg::t_coord oz);
        logic [rft_pkg::CFG_DW-1:0] junk;
        wait_idle();
        junk = rft_pkg::CFG_DW'({$urandom, $urandom});
        write_reg(rft_pkg::REG_BASIS_X, bx);
        write_reg(rft_pkg::REG_BASIS_Y, by);
        write_reg(rft_pkg::REG_BASIS_Z, bz);
        // upper data bits are outside the origin registers
        write_reg(rft_pkg::REG_ORIGIN_X, {junk[rft_pkg::CFG_DW-1:rft_pkg::COORD_W], ox});
        write_reg(rft_pkg::REG_ORIGIN_Y, {~junk[rft_pkg::CFG_DW-1:rft_pkg::COORD_W], oy});
        write_reg(rft_pkg::REG_ORIGIN_Z, {junk[rft_pkg::CFG_DW-1:rft_pkg::COORD_W], oz});
        write_reg(REG_UNUSED_A, junk);
        write_reg(REG_UNUSED_B, ~junk);
        i_cfg_we <= 1'b0;
        frames_loaded++;
    endtask

    task automatic load_random_frame();
        load_frame(basis_row(rand_coef(), rand_coef(), rand_coef()),
                   basis_row(rand_coef(), rand_coef(), rand_coef()),
                   basis_row(rand_coef(), rand_coef(), rand_coef()),
                   rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic check_result();
        t_coord_res exp_r;
        rft_pkg::t_coord got [3];
        string axis [3];
        axis = '{"x", "y", "z"};
        got = '{out_if.out_x, out_if.out_y, out_if.out_z};
        if (expected_q.size() == 0) begin
            $display("%0t: result with no item pending: x=%0d y=%0d z=%0d overflow=%b",
                     $time, got[0], got[1], got[2], out_if.overflow);
            err_count++;
            return;
        end
        exp_r = expected_q.pop_front();
        results_checked++;
        if (out_if.overflow === 1'b1)
            sat_results++;
        for (int i = 0; i < 3; i++) begin
            if (got[i] !== exp_r.c[i]) begin
                $display("%0t: out_%s mismatch: expected %0d, actual %0d",
                         $time, axis[i], exp_r.c[i], got[i]);
                err_count++;
            end
        end
        if (out_if.overflow !== exp_r.ovf) begin
            $display("%0t: overflow mismatch: expected %b, actual %b",
                     $time, exp_r.ovf, out_if.overflow);
            err_count++;
        end
    endtask

    // result side: random stalls, plus a long hold when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
                check_result();
            if (stall_burst)
                hold_left = HOLD_LEN;
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    task automatic test_reset_frame();
        // identity basis and zero origin straight out of reset
        send_item(mk_req(OP_TO_LOCAL, DIR_POINT, '0, '0, '0));
        send_item(mk_req(OP_TO_LOCAL, DIR_POINT, C_MAX, C_MIN, rft_pkg::t_coord'(1)));
        send_item(mk_req(rft_pkg::OP_TO_GLOBAL, DIR_POINT, C_MIN, C_MAX,
                         rft_pkg::t_coord'(-1)));
        send_item(mk_req(OP_TO_LOCAL, rft_pkg::DIR_VECTOR, C_MAX, C_MAX, C_MAX));
        send_item(mk_req(rft_pkg::OP_TO_GLOBAL, rft_pkg::DIR_VECTOR, C_MIN, C_MIN, C_MIN));
    endtask

    task automatic test_rounding_ties();
        // one lsb coefficients put results exactly on half steps
        load_frame(basis_row(LSB_COEF, LSB_COEF, LSB_COEF),
                   basis_row(LSB_COEF, LSB_COEF, LSB_COEF),
                   basis_row(LSB_COEF, LSB_COEF, LSB_COEF), '0, '0, '0);
        send_item(mk_req(OP_TO_LOCAL, DIR_POINT, rft_pkg::t_coord'(8192), '0, '0));
        send_item(mk_req(OP_TO_LOCAL, DIR_POINT, rft_pkg::t_coord'(-8192), '0, '0));
        send_item(mk_req(OP_TO_LOCAL, DIR_POINT, rft_pkg::t_coord'(24576), '0, '0));
        send_item(mk_req(OP_TO_LOCAL, DIR_POINT, rft_pkg::t_coord'(-24576), '0, '0));
        send_item(mk_req(rft_pkg::OP_TO_GLOBAL, rft_pkg::DIR_VECTOR,
                         rft_pkg::t_coord'(8192), '0, '0));
    endtask

    task automatic test_extreme_frames();
        load_frame(basis_row(NEG_TWO, NEG_TWO, NEG_TWO),
                   basis_row(NEG_TWO, NEG_TWO, NEG_TWO),
                   basis_row(NEG_TWO, NEG_TWO, NEG_TWO),
                   C_MIN, C_MAX, C_MIN);
        send_item(mk_req(OP_TO_LOCAL, DIR_POINT, C_MAX, C_MIN, C_MAX));
        send_item(mk_req(rft_pkg::OP_TO_GLOBAL, DIR_POINT, C_MIN, C_MIN, C_MIN));
        send_item(mk_req(OP_TO_LOCAL, rft_pkg::DIR_VECTOR, rft_pkg::t_coord'(1),
                         rft_pkg::t_coord'(1), rft_pkg::t_coord'(1)));
        send_item(mk_req(rft_pkg::OP_TO_GLOBAL, rft_pkg::DIR_VECTOR, C_MAX, '0, C_MIN));
        load_frame(basis_row(MAX_COEF, MAX_COEF, MAX_COEF),
                   basis_row(MAX_COEF, MAX_COEF, MAX_COEF),
                   basis_row(MAX_COEF, MAX_COEF, MAX_COEF),
                   C_MAX, C_MAX, C_MAX);
        send_item(mk_req(rft_pkg::OP_TO_GLOBAL, DIR_POINT, C_MAX, C_MAX, C_MAX));
        send_item(mk_req(OP_TO_LOCAL, DIR_POINT, C_MIN, C_MIN, C_MIN));
        send_item(mk_req(OP_TO_LOCAL, rft_pkg::DIR_VECTOR, '0, '0, '0));
    endtask

    task automatic test_rotation_frame();
        // quarter turn about z, origin at (1.5, -2.25, 10)
        load_frame(basis_row(ZERO_COEF, ONE_Q14, ZERO_COEF),
                   basis_row(-ONE_Q14, ZERO_COEF, ZERO_COEF),
                   basis_row(ZERO_COEF, ZERO_COEF, ONE_Q14),
                   rft_pkg::t_coord'(98304), rft_pkg::t_coord'(-147456),
                   rft_pkg::t_coord'(655360));
        send_item(mk_req(OP_TO_LOCAL, DIR_POINT, rft_pkg::t_coord'(196608),
                         rft_pkg::t_coord'(262144), rft_pkg::t_coord'(327680)));
        send_item(mk_req(rft_pkg::OP_TO_GLOBAL, DIR_POINT, rft_pkg::t_coord'(49152),
                         rft_pkg::t_coord'(-65536), rft_pkg::t_coord'(131072)));
        send_item(mk_req(rft_pkg::OP_TO_GLOBAL, rft_pkg::DIR_VECTOR,
                         rft_pkg::t_coord'(49152), rft_pkg::t_coord'(-65536),
                         rft_pkg::t_coord'(131072)));
    endtask

    task automatic test_random_frames();
        src_idle_pct = 35;
        snk_idle_pct = 35;
        for (int f = 0; f < 9; f++) begin
            load_random_frame();
            repeat (150) send_item(rand_req());
        end
    endtask

    task automatic test_back_to_back();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        load_random_frame();
        repeat (300) send_item(rand_req());
        src_idle_pct = 35;
        snk_idle_pct = 35;
    endtask

    task automatic test_output_stall();
        // result side holds off while items keep coming, the pipe must fill and stall
        load_random_frame();
        src_idle_pct = 0;
        stall_burst <= 1'b1;
        @(posedge i_clk);
        stall_burst <= 1'b0;
        repeat (80) send_item(rand_req());
        src_idle_pct = 35;
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= '0;
        i_cfg_data         <= '0;
        in_if.valid        <= 1'b0;
        in_if.op           <= 1'b0;
        in_if.is_direction <= 1'b0;
        in_if.in_x         <= '0;
        in_if.in_y         <= '0;
        in_if.in_z         <= '0;
        reset_frame_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_frame();
        test_rounding_ties();
        test_extreme_frames();
        test_rotation_frame();
        test_random_frames();
        test_back_to_back();
        test_output_stall();
        wait_idle();

        $display("covered %0d items across %0d frame settings in both directions,",
                 items_sent, frames_loaded);
        $display("points and directions; %0d results checked, %0d of them saturated",
                 results_checked, sat_results);
        if (err_count == 0) begin
            $display("rigid_frame_transform_top test passed");
        end else begin
            $display("%0d errors", err_count);
            $display("rigid_frame_transform_top test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
        $display("rigid_frame_transform_top test failed");
        $finish;
    end

endmodule
